### rtl/vbs_pkg.sv
// Package for the voxel bitmap store: payload structs, request codes, sizes.
// No dependencies.
package vbs_pkg;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_FSET   = 3'd2;
  localparam logic [2:0] REQ_FCLR   = 3'd3;
  localparam logic [2:0] REQ_COUNT  = 3'd4;
  localparam logic [2:0] REQ_CLRALL = 3'd5;

  localparam logic [1:0] CFG_SX = 2'd0;
  localparam logic [1:0] CFG_SY = 2'd1;
  localparam logic [1:0] CFG_SZ = 2'd2;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        by_index;
    logic [9:0]  x_pos;
    logic [9:0]  y_pos;
    logic [9:0]  z_pos;
    logic [29:0] linear_index;
    logic        write_value;
  } vbs_in_t;

  typedef struct packed {
    logic        bit_value;
    logic        in_range;
    logic [30:0] found_index;
    logic [16:0] set_count;
    logic [29:0] coord_x;
    logic [9:0]  coord_y;
    logic [9:0]  coord_z;
  } vbs_out_t;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [30:0] dividend;
    logic [21:0] divisor;
  } vbs_div_req_t;

endpackage

### rtl/vbs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on vbs_pkg. A zero divisor yields quotient and remainder 0.
module vbs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vbs_pkg::vbs_div_req_t req,
  output logic                  done,
  output logic [30:0]           quot,
  output logic [30:0]           rem
);
  import vbs_pkg::*;

  logic [30:0] q_r, q_nxt;
  logic [31:0] r_r, r_nxt;
  logic [21:0] d_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        zero_r;
  logic [31:0] shifted;

  always_comb begin
    shifted  = {r_r[30:0], q_r[30]};
    q_nxt    = {q_r[29:0], 1'b0};
    r_nxt    = shifted;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (shifted >= {10'd0, d_r}) begin
      r_nxt    = shifted - {10'd0, d_r};
      q_nxt[0] = 1'b1;
    end
    if (busy_r) begin
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd30;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r    <= req.dividend;
      r_r    <= '0;
      d_r    <= req.divisor;
      zero_r <= (req.divisor == '0);
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : q_r;
  assign rem  = zero_r ? '0 : r_r[30:0];
endmodule

### rtl/vbs_mem.sv
// Voxel bit memory, one write port and one registered read port.
// Depends on nothing; depth given by parameter.
module vbs_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### rtl/voxel_bitmap_store_top.sv
// Voxel bitmap store top: sequencer around a 1-bit voxel memory and a divider.
// A read or write by index first runs two divides; find and count walk the voxels in turn,
// and a find hit then runs two divides to give its coordinates.
// One transaction in progress at a time; a finished result waits in the output register
// while the next transaction is accepted. Reset (synchronous, rst_n low) sets sizes to 16,
// then a clearing pass over all MAX_VOXELS addresses zeroes the memory. Clear all is a pass too.
module voxel_bitmap_store_top #(
  parameter int unsigned MAX_VOXELS = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vbs_pkg::vbs_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output vbs_pkg::vbs_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [10:0]      cfg_data
);
  import vbs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VOXELS);
  localparam logic [31:0] MAXV = 32'(MAX_VOXELS);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DIV1  = 4'd2;
  localparam logic [3:0] ST_DIV2  = 4'd3;
  localparam logic [3:0] ST_ADDR  = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_WALK  = 4'd7;
  localparam logic [3:0] ST_FOUND = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_TOT   = 4'd10;
  localparam logic [3:0] ST_PLANE = 4'd11;
  localparam logic [3:0] ST_WAIT  = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  logic [3:0]  st_r;
  logic [10:0] sx_r, sy_r, sz_r;
  vbs_in_t     req_r;
  vbs_out_t    res_r;
  vbs_out_t    out_r;
  logic        out_valid_r;
  logic [AW:0] ptr_r;
  logic [31:0] tot_r;
  logic [21:0] plane_r;
  logic [31:0] prod_r;
  logic [29:0] x_r;
  logic [9:0]  y_r, z_r;
  logic [31:0] idx_r;
  logic [16:0] cnt_r;
  logic [30:0] walk_r;
  logic        div_phase_r;
  logic [1:0]  pend_r;

  vbs_div_req_t div_req;
  logic         div_done;
  logic [30:0]  div_q, div_rem;
  logic         mem_we, mem_wd, mem_rd;
  logic [AW-1:0] mem_wa, mem_ra;

  vbs_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  vbs_mem #(.DEPTH(MAX_VOXELS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(mem_rd)
  );

  logic accept;
  logic ok;
  logic walk_hit;
  logic walk_end;
  logic out_load;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load = (st_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign ok = ({1'b0, x_r} < {20'd0, sx_r}) && (y_r < sy_r[9:0] || sy_r[10])
           && (z_r < sz_r[9:0] || sz_r[10]) && (idx_r < MAXV);
  assign walk_end = ({1'b0, walk_r} >= tot_r);
  assign walk_hit = (mem_rd == (req_r.req_type == REQ_FSET));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = req_r.write_value;
    mem_ra = idx_r[AW-1:0];
    if (st_r == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = ptr_r[AW-1:0];
      mem_wd = 1'b0;
    end else if (st_r == ST_ACC && req_r.req_type == REQ_WRITE && ok) begin
      mem_we = 1'b1;
    end
    if (st_r == ST_WALK) mem_ra = walk_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= 11'd16; sy_r <= 11'd16; sz_r <= 11'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SX: sx_r <= cfg_data;
        CFG_SY: sy_r <= cfg_data;
        CFG_SZ: sz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      ptr_r <= '0;
      out_valid_r <= 1'b0;
      div_req <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (st_r)
        ST_CLR: begin
          if (ptr_r == (AW+1)'(MAX_VOXELS - 1)) begin
            ptr_r <= '0;
            st_r <= ST_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_r <= in_data;
            res_r <= '0;
            st_r <= ST_PLANE;
          end
        end
        ST_PLANE: begin
          plane_r <= 22'(sy_r * sz_r);
          st_r <= ST_TOT;
        end
        ST_TOT: begin
          // product sx * plane; it is capped to MAXV in ST_WAIT
          prod_r <= 32'(sx_r * plane_r);
          if (req_r.req_type == REQ_READ || req_r.req_type == REQ_WRITE) begin
            if (req_r.by_index) begin
              div_req <= '{start: 1'b1, dividend: {1'b0, req_r.linear_index},
                           divisor: plane_r};
              div_phase_r <= 1'b0;
              st_r <= ST_DIV1;
            end else begin
              x_r <= {20'd0, req_r.x_pos};
              y_r <= req_r.y_pos;
              z_r <= req_r.z_pos;
              st_r <= ST_ADDR;
            end
          end else if (req_r.req_type == REQ_FSET || req_r.req_type == REQ_FCLR
                       || req_r.req_type == REQ_COUNT) begin
            st_r <= ST_WAIT;
          end else begin
            st_r <= ST_DONE;
          end
        end
        ST_WAIT: begin
          tot_r <= (prod_r < MAXV) ? prod_r : MAXV;
          walk_r <= (req_r.req_type == REQ_COUNT) ? '0 : {1'b0, req_r.linear_index};
          cnt_r <= '0;
          pend_r <= 2'd0;
          st_r <= ST_WALK;
        end
        ST_DIV1: begin
          if (div_done) begin
            x_r <= div_q[29:0];
            // with an empty plane z still comes from the whole index
            div_req <= '{start: 1'b1,
                         dividend: (plane_r == '0) ? {1'b0, req_r.linear_index} : div_rem,
                         divisor: {11'd0, sz_r}};
            st_r <= ST_DIV2;
          end else begin
            div_req.start <= 1'b0;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            y_r <= div_q[9:0];
            z_r <= div_rem[9:0];
            st_r <= div_phase_r ? ST_OUT : ST_ADDR;
          end else begin
            div_req.start <= 1'b0;
          end
        end
        ST_ADDR: begin
          idx_r <= 32'(x_r * plane_r) + 32'(y_r * sz_r) + {22'd0, z_r};
          st_r <= ST_ACC;
        end
        ST_ACC: begin
          st_r <= ST_RD;
        end
        ST_RD: begin
          res_r.in_range <= ok;
          res_r.bit_value <= (req_r.req_type == REQ_READ) && ok && mem_rd;
          res_r.coord_x <= x_r;
          res_r.coord_y <= y_r;
          res_r.coord_z <= z_r;
          st_r <= ST_DONE;
        end
        ST_WALK: begin
          // per voxel: issue the read, then use the data
          if (pend_r == 2'd0) begin
            if (walk_end) begin
              if (req_r.req_type != REQ_COUNT) res_r.found_index <= tot_r[30:0];
              res_r.set_count <= cnt_r;
              st_r <= ST_DONE;
            end else begin
              pend_r <= 2'd1;
            end
          end else begin
            pend_r <= 2'd0;
            if (req_r.req_type == REQ_COUNT) begin
              if (mem_rd && cnt_r != CNT_MAX) cnt_r <= cnt_r + 17'd1;
              walk_r <= walk_r + 31'd1;
            end else if (walk_hit) begin
              st_r <= ST_FOUND;
            end else begin
              walk_r <= walk_r + 31'd1;
            end
          end
        end
        ST_FOUND: begin
          res_r.in_range <= 1'b1;
          res_r.found_index <= walk_r;
          div_req <= '{start: 1'b1, dividend: walk_r, divisor: plane_r};
          div_phase_r <= 1'b1;
          st_r <= ST_DIV1;
        end
        ST_OUT: begin
          res_r.coord_x <= x_r;
          res_r.coord_y <= y_r;
          res_r.coord_z <= z_r;
          st_r <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_r <= res_r;
            st_r <= (req_r.req_type == REQ_CLRALL) ? ST_CLR : ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLR) |-> !accept) else $error("accept during clear");
  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("not stalled while busy");
  a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLR) |-> (mem_we && !mem_wd)) else $error("clear pass write");
`endif
endmodule

### bench/voxel_bitmap_store_top_test.sv
// Self-checking testbench for voxel_bitmap_store_top: directed table, then random phases
// over several volume sizes, each result checked against a table entry or an in-bench bitmap model.
// Depends on rtl/vbs_pkg.sv and rtl/voxel_bitmap_store_top.sv.
module voxel_bitmap_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vbs_pkg::*;

  localparam int unsigned VOXEL_CAP = 65536;
  localparam int NUM_ROWS = 19;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vbs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vbs_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SX;
  logic [10:0] cfg_data = '0;

  voxel_bitmap_store_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bitmap model state
  bit voxel_mem [VOXEL_CAP];
  longint unsigned dim_x = 16, dim_y = 16, dim_z = 16;
  vbs_out_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;

  // Directed table
  vbs_in_t dir_req [NUM_ROWS];
  bit dir_typed [NUM_ROWS];
  vbs_out_t dir_exp [NUM_ROWS];

  function automatic longint unsigned volume_total();
    longint unsigned t;
    t = dim_x * dim_y * dim_z;
    return (t < VOXEL_CAP) ? t : VOXEL_CAP;
  endfunction

  function automatic void split_index(input longint unsigned i, output longint unsigned x,
                                      output longint unsigned y, output longint unsigned z);
    longint unsigned plane;
    plane = dim_y * dim_z;
    x = (plane != 0) ? i / plane : 0;
    y = (plane != 0 && dim_z != 0) ? (i % plane) / dim_z : 0;
    z = (dim_z != 0) ? i % dim_z : 0;
  endfunction

  function automatic vbs_out_t predict_voxel(vbs_in_t r);
    vbs_out_t o;
    longint unsigned x, y, z, idx, tot, i, cnt;
    bit ok, want;
    o = '0;
    case (r.req_type)
      REQ_READ, REQ_WRITE: begin
        if (r.by_index) begin
          split_index(r.linear_index, x, y, z);
        end else begin
          x = r.x_pos;
          y = r.y_pos;
          z = r.z_pos;
        end
        idx = x * dim_y * dim_z + y * dim_z + z;
        ok = x < dim_x && y < dim_y && z < dim_z && idx < VOXEL_CAP;
        if (r.req_type == REQ_READ) begin
          o.bit_value = ok && voxel_mem[idx];
        end else if (ok) begin
          voxel_mem[idx] = r.write_value;
        end
        o.in_range = ok;
        o.coord_x = x[29:0];
        o.coord_y = y[9:0];
        o.coord_z = z[9:0];
      end
      REQ_FSET, REQ_FCLR: begin
        want = (r.req_type == REQ_FSET);
        tot = volume_total();
        ok = 1'b0;
        for (i = r.linear_index; i < tot; i++) begin
          if (voxel_mem[i] == want) begin
            ok = 1'b1;
            break;
          end
        end
        if (!ok) i = tot;
        o.in_range = ok;
        o.found_index = i[30:0];
        if (ok) begin
          split_index(i, x, y, z);
          o.coord_x = x[29:0];
          o.coord_y = y[9:0];
          o.coord_z = z[9:0];
        end
      end
      REQ_COUNT: begin
        tot = volume_total();
        cnt = 0;
        for (i = 0; i < tot; i++) cnt += voxel_mem[i];
        o.set_count = (cnt > CNT_MAX) ? CNT_MAX : cnt[16:0];
      end
      REQ_CLRALL: begin
        foreach (voxel_mem[k]) voxel_mem[k] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic vbs_in_t mk_req(logic [2:0] op, int byi, int x, int y, int z,
                                     int li, int wv);
    vbs_in_t r;
    r.req_type = op;
    r.by_index = 1'(byi);
    r.x_pos = 10'(x);
    r.y_pos = 10'(y);
    r.z_pos = 10'(z);
    r.linear_index = 30'(li);
    r.write_value = 1'(wv);
    return r;
  endfunction

  function automatic vbs_out_t mk_res(int bv, int ir, int fi, int cnt,
                                      int cx, int cy, int cz);
    vbs_out_t o;
    o = '{1'(bv), 1'(ir), 31'(fi), 17'(cnt), 30'(cx), 10'(cy), 10'(cz)};
    return o;
  endfunction

  function automatic int pick_coord(longint unsigned dim);
    if ($urandom_range(0, 3) == 0 || dim == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, 32'((dim > 1024 ? 1024 : dim) - 1));
  endfunction

  function automatic logic [29:0] pick_index(longint unsigned tot);
    if ($urandom_range(0, 9) < 3) return 30'($urandom);
    return 30'($urandom_range(0, 32'(tot + 3)));
  endfunction

  // Large volumes: keep walks short, counts rare
  function automatic vbs_in_t random_req(bit big);
    vbs_in_t r;
    int pct;
    longint unsigned tot;
    tot = volume_total();
    pct = $urandom_range(0, 99);
    r = mk_req(REQ_READ, $urandom_range(0, 1), pick_coord(dim_x), pick_coord(dim_y),
               pick_coord(dim_z), pick_index(tot), $urandom_range(0, 1));
    if (pct < 35) r.req_type = REQ_WRITE;
    else if (pct < 60) r.req_type = REQ_READ;
    else if (pct < 75) r.req_type = REQ_FSET;
    else if (pct < 87) r.req_type = REQ_FCLR;
    else if (pct < (big ? 89 : 95)) r.req_type = REQ_COUNT;
    else if (pct < 98) r.req_type = REQ_READ;
    else r.req_type = 3'(6 + $urandom_range(0, 1));
    if ($urandom_range(0, 199) == 0) r.req_type = REQ_CLRALL;
    if (big && (r.req_type == REQ_FSET || r.req_type == REQ_FCLR) &&
        $urandom_range(0, 9) != 0)
      r.linear_index = 30'(tot - $urandom_range(0, 300));
    return r;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_req(vbs_in_t r, bit typed, vbs_out_t exp, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    begin
      vbs_out_t p;
      p = predict_voxel(r);
      pending_results.push_back(typed ? exp : p);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic set_volume(int sx, int sy, int sz);
    int vals [3];
    vals = '{sx, sy, sz};
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
    for (int k = 0; k < 3; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[1:0];
      cfg_data <= vals[k][10:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    dim_x = sx;
    dim_y = sy;
    dim_z = sz;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        errors++;
      end else begin
        vbs_out_t e;
        e = pending_results.pop_front();
        if (out_data.bit_value !== e.bit_value || out_data.in_range !== e.in_range ||
            out_data.found_index !== e.found_index || out_data.set_count !== e.set_count ||
            out_data.coord_x !== e.coord_x || out_data.coord_y !== e.coord_y ||
            out_data.coord_z !== e.coord_z) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int w;
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 250) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
      end
      w = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 10);
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #40ms;
    $display("voxel_bitmap_store_top test failed");
    $finish;
  end

  initial begin
    int phase_dims [NUM_PHASES][3];
    vbs_out_t none;
    none = '0;
    phase_dims = '{'{0, 5, 5}, '{1, 1, 1}, '{3, 4, 5}, '{1024, 1024, 1024},
                   '{7, 1, 9}, '{2, 1024, 1}, '{16, 16, 16}};

    dir_req[0]  = mk_req(REQ_READ, 0, 0, 0, 0, 0, 0);
    dir_exp[0]  = mk_res(0, 1, 0, 0, 0, 0, 0);
    dir_req[1]  = mk_req(REQ_COUNT, 0, 0, 0, 0, 0, 0);
    dir_exp[1]  = none;
    dir_req[2]  = mk_req(REQ_FSET, 1, 0, 0, 0, 0, 0);
    dir_exp[2]  = mk_res(0, 0, 4096, 0, 0, 0, 0);
    dir_req[3]  = mk_req(REQ_FCLR, 0, 0, 0, 0, 0, 0);
    dir_exp[3]  = mk_res(0, 1, 0, 0, 0, 0, 0);
    dir_req[4]  = mk_req(REQ_WRITE, 0, 15, 15, 15, 0, 1);
    dir_exp[4]  = mk_res(0, 1, 0, 0, 15, 15, 15);
    dir_req[5]  = mk_req(REQ_READ, 1, 0, 0, 0, 4095, 0);
    dir_exp[5]  = mk_res(1, 1, 0, 0, 15, 15, 15);
    dir_req[6]  = mk_req(REQ_WRITE, 0, 16, 0, 0, 0, 1);
    dir_exp[6]  = mk_res(0, 0, 0, 0, 16, 0, 0);
    dir_req[7]  = mk_req(REQ_WRITE, 0, 1023, 1023, 1023, 30'h3FFFFFFF, 1);
    dir_exp[7]  = mk_res(0, 0, 0, 0, 1023, 1023, 1023);
    dir_req[8]  = mk_req(REQ_READ, 1, 1023, 1023, 1023, 30'h3FFFFFFF, 1);
    dir_req[9]  = mk_req(REQ_FSET, 0, 0, 0, 0, 0, 0);
    dir_req[10] = mk_req(REQ_FSET, 0, 0, 0, 0, 30'h3FFFFFFF, 0);
    dir_exp[10] = mk_res(0, 0, 4096, 0, 0, 0, 0);
    dir_req[11] = mk_req(REQ_FCLR, 0, 0, 0, 0, 4095, 0);
    dir_req[12] = mk_req(REQ_WRITE, 1, 0, 0, 0, 100, 1);
    dir_req[13] = mk_req(REQ_COUNT, 0, 0, 0, 0, 0, 0);
    dir_req[14] = mk_req(REQ_CLRALL, 0, 0, 0, 0, 0, 0);
    dir_exp[14] = none;
    dir_req[15] = mk_req(REQ_COUNT, 0, 0, 0, 0, 0, 0);
    dir_exp[15] = none;
    dir_req[16] = mk_req(3'(6), 1, 1023, 1023, 1023, 30'h3FFFFFFF, 1);
    dir_exp[16] = none;
    dir_req[17] = mk_req(3'(7), 1, 5, 5, 5, 77, 1);
    dir_exp[17] = none;
    dir_req[18] = mk_req(REQ_WRITE, 0, 0, 0, 0, 30'h2AAAAAAA, 1);
    foreach (dir_typed[k]) dir_typed[k] = 1'b0;
    foreach (dir_typed[k])
      if (k inside {0, 1, 2, 3, 4, 5, 6, 7, 10, 14, 15, 16, 17}) dir_typed[k] = 1'b1;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NUM_ROWS; k++) send_req(dir_req[k], dir_typed[k], dir_exp[k], 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_volume(phase_dims[p][0], phase_dims[p][1], phase_dims[p][2]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_req(random_req(phase_dims[p][0] == 1024), 1'b0, none, (items_sent / 50) % 3 == 0);
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("voxel_bitmap_store_top test passed");
    end else begin
      $display("voxel_bitmap_store_top test failed");
    end
    $finish;
  end
endmodule
